/* src/dcwm_pkg.sv */
// Shared types and constants for the duty-cycle window meter.
// No dependencies; used by dcwm_ctrl, dcwm_dp and duty_cycle_window_meter_unit.
package dcwm_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int AMP_W        = 17;
    localparam int DUTY_OUT_W   = 17;
    localparam int DUTY_OUT_FRAC = 16;
    localparam int RECON_W      = 18;
    localparam int SCOUNT_W     = 32;

    localparam logic [AMP_W-1:0] AMP_RESET = 17'h10000;

    // input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLOSE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic sample_en;
        logic close_en;
        logic div_en;
        logic mul_en;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

/* src/duty_cycle_window_meter_unit.sv */
// Duty-cycle window meter, top level. Depends on dcwm_pkg, dcwm_ctrl, dcwm_dp.
// Pin-sample beats: one per cycle while idle, no result; counters update on the accept edge.
// Window-close beat: a result follows once the serial restoring divider (one quotient
//   bit a cycle) and the amplitude multiplier have run, and
//   no input beat is taken until the result sits in the output register.
// Reset (rst_n, async low): counts cleared, amplitude 1.0, no result pending.
module duty_cycle_window_meter_unit #(
    parameter int COUNT_WIDTH = dcwm_pkg::COUNT_WIDTH_DEF,
    parameter int FRAC_BITS   = dcwm_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 command,
    input  logic                                 level,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [dcwm_pkg::DUTY_OUT_W-1:0]      duty_fraction,
    output logic signed [dcwm_pkg::RECON_W-1:0]  reconstructed_value,
    output logic [dcwm_pkg::SCOUNT_W-1:0]        sample_count,
    input  logic                                 cfg_wr_en,
    input  logic [dcwm_pkg::AMP_W-1:0]           cfg_wr_data
);

    dcwm_pkg::dp_cmd_t  cmd;
    dcwm_pkg::dp_stat_t stat;

    dcwm_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    dcwm_dp #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .level               (level),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .cmd                 (cmd),
        .stat                (stat),
        .out_ready           (out_ready),
        .out_valid           (out_valid),
        .duty_fraction       (duty_fraction),
        .reconstructed_value (reconstructed_value),
        .sample_count        (sample_count)
    );

    // a close beat stalls the input while the divider runs
    a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && command == dcwm_pkg::CMD_CLOSE) |=> !in_ready)
        else $error("input ready straight after a window close");

    // an empty window can only report zero duty
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sample_count == '0) |-> (duty_fraction == '0))
        else $error("non-zero duty for an empty window");

    // duty of one half or more never reconstructs a negative value
    a_sign_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && duty_fraction[dcwm_pkg::DUTY_OUT_W-1:dcwm_pkg::DUTY_OUT_W-2] != 2'b00)
        |-> !reconstructed_value[dcwm_pkg::RECON_W-1])
        else $error("negative reconstruction for duty at or above half");

endmodule

/* src/dcwm_ctrl.sv */
// Controller for the duty-cycle window meter: sequences snapshot, divide,
// multiply and output load. Depends on dcwm_pkg.
module dcwm_ctrl #(
    parameter int FRAC_BITS = dcwm_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              command,
    output logic              in_ready,
    output dcwm_pkg::dp_cmd_t cmd,
    input  dcwm_pkg::dp_stat_t stat
);

    localparam int STEP_W = $clog2(FRAC_BITS);

    dcwm_pkg::ctrl_state_t state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  step_last;
    logic                  close_acc;

    assign step_last = (step_reg == STEP_W'(FRAC_BITS - 1));
    assign close_acc = in_valid && (command == dcwm_pkg::CMD_CLOSE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dcwm_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            dcwm_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (close_acc)
                    state_next = dcwm_pkg::ST_DIV;
            end
            dcwm_pkg::ST_DIV:
            begin
                if (step_last)
                begin
                    step_next  = '0;
                    state_next = dcwm_pkg::ST_MUL;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            dcwm_pkg::ST_MUL:
            begin
                state_next = dcwm_pkg::ST_OUT;
            end
            dcwm_pkg::ST_OUT:
            begin
                if (stat.out_free)
                    state_next = dcwm_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        cmd.sample_en = 1'b0;
        cmd.close_en  = 1'b0;
        cmd.div_en    = 1'b0;
        cmd.mul_en    = 1'b0;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            dcwm_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.sample_en = in_valid && (command == dcwm_pkg::CMD_SAMPLE);
                cmd.close_en  = close_acc;
            end
            dcwm_pkg::ST_DIV:
            begin
                cmd.div_en = 1'b1;
            end
            dcwm_pkg::ST_MUL:
            begin
                cmd.mul_en = 1'b1;
            end
            dcwm_pkg::ST_OUT:
            begin
                cmd.out_load = stat.out_free;
            end
        endcase
    end

endmodule

/* src/dcwm_dp.sv */
// Datapath for the duty-cycle window meter: sample counters, serial
// restoring divider, amplitude multiplier and output register. Depends on dcwm_pkg.
module dcwm_dp #(
    parameter int COUNT_WIDTH = dcwm_pkg::COUNT_WIDTH_DEF,
    parameter int FRAC_BITS   = dcwm_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 level,
    input  logic                                 cfg_wr_en,
    input  logic [dcwm_pkg::AMP_W-1:0]           cfg_wr_data,
    input  dcwm_pkg::dp_cmd_t                    cmd,
    output dcwm_pkg::dp_stat_t                   stat,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [dcwm_pkg::DUTY_OUT_W-1:0]      duty_fraction,
    output logic signed [dcwm_pkg::RECON_W-1:0]  reconstructed_value,
    output logic [dcwm_pkg::SCOUNT_W-1:0]        sample_count
);

    localparam int CW     = COUNT_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int DUTY_W = F + 1;
    localparam int DIFF_W = F + 3;
    localparam int AMP_SW = dcwm_pkg::AMP_W + 1;
    localparam int PROD_W = AMP_SW + DIFF_W;
    localparam logic [DIFF_W-1:0] ONE_Q = DIFF_W'(1) << F;

    logic [dcwm_pkg::AMP_W-1:0] amp_reg;
    logic [CW-1:0]              high_reg, tot_reg;
    logic [CW-1:0]              den_reg, rem_reg;
    logic [F-1:0]               q_reg;
    logic                       full_reg, zero_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       out_valid_reg;
    logic [dcwm_pkg::DUTY_OUT_W-1:0]     duty_out_reg;
    logic signed [dcwm_pkg::RECON_W-1:0] recon_reg;
    logic [dcwm_pkg::SCOUNT_W-1:0]       scount_reg;

    logic [CW-1:0]              hi_min_c;
    logic [CW:0]                two_r_c;
    logic                       q_bit_c;
    logic [DUTY_W-1:0]          duty_c;
    logic signed [DIFF_W-1:0]   diff_c;
    logic signed [AMP_SW-1:0]   amp_s_c;
    logic signed [PROD_W-1:0]   prod_c, shr_c;
    logic [dcwm_pkg::DUTY_OUT_W-1:0] d16_c;
    logic [dcwm_pkg::SCOUNT_W-1:0]   scount_c;

    assign hi_min_c = (high_reg > tot_reg) ? tot_reg : high_reg;
    assign two_r_c  = {rem_reg, 1'b0};
    assign q_bit_c  = (two_r_c >= {1'b0, den_reg});

    always_comb
    begin
        priority if (zero_reg)
            duty_c = '0;
        else if (full_reg)
            duty_c = DUTY_W'(1) << F;
        else
            duty_c = {1'b0, q_reg};
    end

    // 2*duty - 1.0, signed Q2.F
    assign diff_c  = $signed({1'b0, duty_c, 1'b0} - ONE_Q);
    assign amp_s_c = $signed({1'b0, amp_reg});
    assign prod_c  = amp_s_c * diff_c;
    // arithmetic shift gives the floor on both signs
    assign shr_c   = prod_reg >>> F;

    generate
        if (F >= dcwm_pkg::DUTY_OUT_FRAC)
        begin : g_frac_narrow
            assign d16_c = dcwm_pkg::DUTY_OUT_W'(duty_c >> (F - dcwm_pkg::DUTY_OUT_FRAC));
        end
        else
        begin : g_frac_widen
            assign d16_c = dcwm_pkg::DUTY_OUT_W'(duty_c) << (dcwm_pkg::DUTY_OUT_FRAC - F);
        end

        if (CW > dcwm_pkg::SCOUNT_W)
        begin : g_count_sat
            assign scount_c = (|den_reg[CW-1:dcwm_pkg::SCOUNT_W]) ? '1
                                                                   : den_reg[dcwm_pkg::SCOUNT_W-1:0];
        end
        else
        begin : g_count_ext
            assign scount_c = dcwm_pkg::SCOUNT_W'(den_reg);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg       <= dcwm_pkg::AMP_RESET;
            high_reg      <= '0;
            tot_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                amp_reg <= cfg_wr_data;

            priority if (cmd.close_en)
            begin
                high_reg <= '0;
                tot_reg  <= '0;
            end
            else if (cmd.sample_en)
            begin
                if (!(&tot_reg))
                    tot_reg <= tot_reg + CW'(1);
                if (level && !(&high_reg))
                    high_reg <= high_reg + CW'(1);
            end
            else
            begin
                high_reg <= high_reg;
                tot_reg  <= tot_reg;
            end

            priority if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            else
                out_valid_reg <= out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.close_en)
        begin
            den_reg  <= tot_reg;
            rem_reg  <= hi_min_c;
            full_reg <= (hi_min_c >= tot_reg);
            zero_reg <= (tot_reg == '0);
            q_reg    <= '0;
        end
        else if (cmd.div_en)
        begin
            // one quotient bit per cycle; remainder stays below den except for a full or empty window
            q_reg <= {q_reg[F-2:0], q_bit_c};
            if (q_bit_c)
                rem_reg <= CW'(two_r_c - {1'b0, den_reg});
            else
                rem_reg <= CW'(two_r_c);
        end

        if (cmd.mul_en)
            prod_reg <= prod_c;

        if (cmd.out_load)
        begin
            duty_out_reg <= d16_c;
            recon_reg    <= shr_c[dcwm_pkg::RECON_W-1:0];
            scount_reg   <= scount_c;
        end
    end

    assign stat.out_free       = !out_valid_reg || out_ready;
    assign out_valid           = out_valid_reg;
    assign duty_fraction       = duty_out_reg;
    assign reconstructed_value = recon_reg;
    assign sample_count        = scount_reg;

endmodule

/* verif/tb_duty_cycle_window_meter_unit.sv */
// Self-checking bench for duty_cycle_window_meter_unit: pin-sample and window-close
// beats in, duty/reconstruction reports out, checked against a cycle-free predictor.
// Depends on dcwm_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module tb_duty_cycle_window_meter_unit;

    localparam int FRAC           = dcwm_pkg::FRAC_BITS_DEF;
    localparam int DRAIN_CYCLES   = FRAC + 8;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS    = 230;
    localparam int CYCLE_LIMIT    = 250000;

    typedef struct {
        logic command;
        logic level;
    } pin_beat_t;

    typedef struct {
        logic [dcwm_pkg::DUTY_OUT_W-1:0]      duty;
        logic signed [dcwm_pkg::RECON_W-1:0]  recon;
        logic [dcwm_pkg::SCOUNT_W-1:0]        count;
    } meter_report_t;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  in_valid = 1'b0;
    logic                                  in_ready;
    logic                                  command = dcwm_pkg::CMD_SAMPLE;
    logic                                  level = 1'b0;
    logic                                  out_valid;
    logic                                  out_ready = 1'b0;
    logic [dcwm_pkg::DUTY_OUT_W-1:0]       duty_fraction;
    logic signed [dcwm_pkg::RECON_W-1:0]   reconstructed_value;
    logic [dcwm_pkg::SCOUNT_W-1:0]         sample_count;
    logic                                  cfg_wr_en = 1'b0;
    logic [dcwm_pkg::AMP_W-1:0]            cfg_wr_data = '0;

    pin_beat_t      queued_beats[$];
    meter_report_t  due_reports[$];
    pin_beat_t      drive_beat;
    meter_report_t  want;

    // predictor state
    logic [dcwm_pkg::AMP_W-1:0]            amp_setting = dcwm_pkg::AMP_RESET;
    logic [dcwm_pkg::COUNT_WIDTH_DEF-1:0]  high_count = '0;
    logic [dcwm_pkg::COUNT_WIDTH_DEF-1:0]  total_count = '0;

    int  send_idle_pct = 7;
    int  recv_idle_pct = 53;
    logic rx_hold = 1'b0;
    event rx_hold_go;
    int  error_count = 0;
    int  cycle_count = 0;

    duty_cycle_window_meter_unit DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .command             (command),
        .level               (level),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .duty_fraction       (duty_fraction),
        .reconstructed_value (reconstructed_value),
        .sample_count        (sample_count),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Counts one accepted beat; a window close yields the expected report.
    function automatic void count_pin_beat(input logic cmd, input logic lvl);
        logic [63:0]   hi;
        logic [63:0]   tot;
        logic [63:0]   duty;
        longint        prod;
        meter_report_t rep;
        if (cmd == dcwm_pkg::CMD_SAMPLE)
        begin
            if (total_count != '1)
                total_count = total_count + 1'b1;
            if (lvl && high_count != '1)
                high_count = high_count + 1'b1;
            return;
        end
        tot = 64'(total_count);
        hi  = (64'(high_count) > tot) ? tot : 64'(high_count);
        if (tot == 0)
            duty = 0;
        else if (hi >= tot)
            duty = 64'd1 << FRAC;
        else
            duty = (hi << FRAC) / tot;
        // floor shift of the signed product gives round-down on both sides of zero
        prod = longint'(64'(amp_setting)) * (longint'(duty) * 2 - (longint'(1) << FRAC));
        rep.duty  = dcwm_pkg::DUTY_OUT_W'(duty << (dcwm_pkg::DUTY_OUT_FRAC - FRAC));
        rep.recon = dcwm_pkg::RECON_W'(prod >>> FRAC);
        rep.count = (tot > 64'hFFFF_FFFF) ? '1 : dcwm_pkg::SCOUNT_W'(tot);
        due_reports.push_back(rep);
        high_count  = '0;
        total_count = '0;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                count_pin_beat(command, level);
            if (!in_valid || in_ready)
            begin
                if (queued_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drive_beat = queued_beats.pop_front();
                    in_valid <= 1'b1;
                    command  <= drive_beat.command;
                    level    <= drive_beat.level;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_reports.size() == 0)
                begin
                    error_count++;
                    $display("%0t: report beat with none expected (duty %0d recon %0d count %0d)",
                             $time, duty_fraction, reconstructed_value, sample_count);
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (duty_fraction !== want.duty)
                    begin
                        error_count++;
                        $display("%0t: duty_fraction expected %0d actual %0d",
                                 $time, want.duty, duty_fraction);
                    end
                    if (reconstructed_value !== want.recon)
                    begin
                        error_count++;
                        $display("%0t: reconstructed_value expected %0d actual %0d",
                                 $time, want.recon, reconstructed_value);
                    end
                    if (sample_count !== want.count)
                    begin
                        error_count++;
                        $display("%0t: sample_count expected %0d actual %0d",
                                 $time, want.count, sample_count);
                    end
                end
            end
            out_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off, timed here so the sender keeps offering beats meanwhile
    always
    begin
        @(rx_hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("duty_cycle_window_meter_unit: mismatch");
            $finish;
        end
    end

    function automatic void queue_beat(input logic cmd, input logic lvl);
        pin_beat_t b;
        b.command = cmd;
        b.level   = lvl;
        queued_beats.push_back(b);
    endfunction

    // n samples with the given pattern of levels, LSB first, then a close
    function automatic void queue_window(input int n, input logic [7:0] levels,
                                         input logic close_level);
        for (int i = 0; i < n; i++)
            queue_beat(dcwm_pkg::CMD_SAMPLE, levels[i]);
        queue_beat(dcwm_pkg::CMD_CLOSE, close_level);
    endfunction

    // Random windows: mostly short, some long, with a per-window duty style.
    task automatic queue_random_windows(input int budget);
        int produced;
        int win_len;
        int style;
        int high_pct;
        logic lvl;
        produced = 0;
        while (produced < budget)
        begin
            case ($urandom_range(19))
                0:       win_len = $urandom_range(121, 300);
                1, 2, 3: win_len = $urandom_range(25, 120);
                default: win_len = $urandom_range(0, 24);
            endcase
            style    = $urandom_range(3);
            high_pct = $urandom_range(100);
            for (int i = 0; i < win_len; i++)
            begin
                case (style)
                    0:       lvl = 1'b0;
                    1:       lvl = 1'b1;
                    2:       lvl = 1'($urandom_range(1));
                    default: lvl = ($urandom_range(99) < high_pct);
                endcase
                queue_beat(dcwm_pkg::CMD_SAMPLE, lvl);
            end
            queue_beat(dcwm_pkg::CMD_CLOSE, 1'($urandom_range(1)));
            produced += win_len + 1;
        end
    endtask

    // Returns once every beat is sent, every report checked and the divider has settled.
    task automatic wait_drained;
        @(negedge clk);
        while (queued_beats.size() != 0 || due_reports.size() != 0 || in_valid)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_amplitude(input logic [dcwm_pkg::AMP_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        amp_setting = value;
    endtask

    initial
    begin
        logic [dcwm_pkg::AMP_W-1:0] amp_list[6];
        int                         idle_list[6][2];
        amp_list[0] = dcwm_pkg::AMP_W'(1);
        amp_list[1] = '1;
        amp_list[2] = '0;
        amp_list[3] = dcwm_pkg::AMP_W'($urandom_range(1, 65536));
        amp_list[4] = dcwm_pkg::AMP_RESET;
        amp_list[5] = dcwm_pkg::AMP_W'($urandom);
        idle_list = '{'{7, 53}, '{7, 53}, '{53, 7}, '{53, 7}, '{0, 0}, '{0, 0}};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty windows (level ignored on close), all high, all low, fractions
        @(negedge clk);
        queue_window(0, 8'b0, 1'b0);
        queue_window(0, 8'b0, 1'b1);
        queue_window(1, 8'b1, 1'b0);
        queue_window(1, 8'b0, 1'b1);
        queue_window(2, 8'b01, 1'b0);
        queue_window(3, 8'b001, 1'b1);
        queue_window(3, 8'b011, 1'b0);
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            write_amplitude(amp_list[p]);
            @(negedge clk);
            send_idle_pct = idle_list[p][0];
            recv_idle_pct = idle_list[p][1];
            if (p == 3)
            begin
                // sender pauses mid-phase until the block has emptied
                queue_random_windows(PHASE_ITEMS / 2);
                wait_drained();
                @(negedge clk);
                queue_random_windows(PHASE_ITEMS / 2);
            end
            else
            begin
                queue_random_windows(PHASE_ITEMS);
                if (p == 1)
                    -> rx_hold_go;
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("duty_cycle_window_meter_unit: match");
        else
            $display("duty_cycle_window_meter_unit: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
src/dcwm_pkg.sv
src/dcwm_ctrl.sv
src/dcwm_dp.sv
src/duty_cycle_window_meter_unit.sv
verif/tb_duty_cycle_window_meter_unit.sv
